FILE: rtl/core/audio_frame_fifo_prefill_unit_assert.svh
// assertion macros for the audio frame fifo prefill unit
`ifndef AUDIO_FRAME_FIFO_PREFILL_UNIT_ASSERT_SVH
`define AUDIO_FRAME_FIFO_PREFILL_UNIT_ASSERT_SVH

// condition holds in the same cycle, checked outside reset
`define AFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("afp check failed: same cycle");

// condition holds in the next cycle, checked outside reset
`define AFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("afp check failed: next cycle");

`endif

FILE: rtl/core/afp_pkg.sv
// shared constants and codes for the audio frame fifo prefill unit
`timescale 1ns / 1ps

package afp_pkg;

    // ring geometry
    localparam int DEPTH_FRAMES = 65536;
    localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
    localparam int CNT_W        = $clog2(DEPTH_FRAMES + 1);

    // word and register widths
    localparam int SAMPLE_W     = 16;
    localparam int FRAME_W      = 2 * SAMPLE_W;
    localparam int LEVEL_W      = 17;
    localparam int PLAYED_W     = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;

    // reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] START_LEVEL_RST = LEVEL_W'(16384);

    // item function codes
    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_PULL  = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED     = 2'd0,
        CFG_PAUSED      = 2'd1,
        CFG_VIDEO_MODE  = 2'd2,
        CFG_START_LEVEL = 2'd3
    } t_cfg_idx;

    // ring index advance with wrap
    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
        next_index = (idx == ADDR_W'(DEPTH_FRAMES - 1)) ? '0 : idx + ADDR_W'(1);
    endfunction

endpackage

FILE: rtl/core/audio_frame_fifo_prefill_unit.sv
// stereo playback fifo: frame ring in ram with start watermark and underrun rearm
// every item gives a registered result word in the cycle after it is accepted
// throughput: one item per cycle, busy stays low; a pull reads the frame ram at accept
// and the registered ram read data drives the samples in the result cycle
// reset: synchronous active-low; indices, fill count, draining flag and played count clear,
// ram contents are left as they are; the receiver cannot stall results
`timescale 1ns / 1ps

module audio_frame_fifo_prefill_unit
    import afp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic signed [SAMPLE_W-1:0]   i_left_in,
    input  logic signed [SAMPLE_W-1:0]   i_right_in,
    // configuration port
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // result channel
    output logic                         o_valid,
    output logic signed [SAMPLE_W-1:0]   o_left_out,
    output logic signed [SAMPLE_W-1:0]   o_right_out,
    output logic                         o_push_accepted,
    output logic                         o_silent,
    output logic                         o_underrun,
    output logic [LEVEL_W-1:0]           o_fill_level,
    output logic [PLAYED_W-1:0]          o_played_frames
);

    // configuration registers
    logic                 r_enabled;
    logic                 r_paused;
    logic                 r_video_mode;
    logic [LEVEL_W-1:0]   r_start_level;

    // ring state
    logic [ADDR_W-1:0]    r_rd_idx, n_rd_idx;
    logic [ADDR_W-1:0]    r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_draining, n_draining;
    logic [PLAYED_W-1:0]  r_played, n_played;

    // result registers
    logic                 r_valid;
    logic                 r_acc, n_acc;
    logic                 r_sil, n_sil;
    logic                 r_und, n_und;
    logic                 r_use_ram, n_use_ram;

    logic                 accept;
    logic                 ram_we;
    logic                 ram_re;
    logic [FRAME_W-1:0]   ram_wdata;
    logic [FRAME_W-1:0]   ram_rdata;
    t_func                func;
    logic                 drain_now;

    assign accept = start && !busy;
    assign func   = t_func'(i_func);
    // one item per cycle, never held off
    assign busy   = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b1;
            r_paused      <= 1'b0;
            r_video_mode  <= 1'b0;
            r_start_level <= START_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLED:     r_enabled     <= i_cfg_data[0];
                CFG_PAUSED:      r_paused      <= i_cfg_data[0];
                CFG_VIDEO_MODE:  r_video_mode  <= i_cfg_data[0];
                CFG_START_LEVEL: r_start_level <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // watermark reached or already draining
    assign drain_now = r_draining || (32'(r_count) >= 32'(r_start_level));

    // item decode and next state
    always_comb begin
        n_rd_idx   = r_rd_idx;
        n_wr_idx   = r_wr_idx;
        n_count    = r_count;
        n_draining = r_draining;
        n_played   = r_played;
        n_acc      = 1'b0;
        n_sil      = 1'b0;
        n_und      = 1'b0;
        n_use_ram  = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        case (func)
            FUNC_PUSH: begin
                if (r_enabled && (32'(r_count) < 32'(DEPTH_FRAMES))) begin
                    ram_we   = accept;
                    n_wr_idx = next_index(r_wr_idx);
                    n_count  = r_count + CNT_W'(1);
                    n_acc    = 1'b1;
                end
            end
            FUNC_PULL: begin
                if (!r_enabled || r_paused) begin
                    n_sil = 1'b1;
                end else if (!drain_now) begin
                    // prefill: silence, counted only in video mode
                    n_sil = 1'b1;
                    if (r_video_mode) begin
                        n_played = r_played + PLAYED_W'(1);
                    end
                end else if (r_count != '0) begin
                    n_draining = 1'b1;
                    ram_re     = accept;
                    n_use_ram  = 1'b1;
                    n_rd_idx   = next_index(r_rd_idx);
                    n_count    = r_count - CNT_W'(1);
                    n_played   = r_played + PLAYED_W'(1);
                end else begin
                    // empty while draining: underrun and rearm the watermark
                    n_sil      = 1'b1;
                    n_und      = 1'b1;
                    n_draining = 1'b0;
                end
            end
            FUNC_FLUSH: begin
                n_rd_idx = '0;
                n_wr_idx = '0;
                n_count  = '0;
            end
            default: ;
        endcase
    end

    // ring state and result word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_wr_idx   <= '0;
            r_count    <= '0;
            r_draining <= 1'b0;
            r_played   <= '0;
            r_valid    <= 1'b0;
            r_acc      <= 1'b0;
            r_sil      <= 1'b0;
            r_und      <= 1'b0;
            r_use_ram  <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_rd_idx   <= n_rd_idx;
                r_wr_idx   <= n_wr_idx;
                r_count    <= n_count;
                r_draining <= n_draining;
                r_played   <= n_played;
                r_acc      <= n_acc;
                r_sil      <= n_sil;
                r_und      <= n_und;
                r_use_ram  <= n_use_ram;
            end
        end
    end

    // frame store, left sample in the low half
    assign ram_wdata = {i_right_in, i_left_in};

    afp_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DEPTH_FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // result word outputs
    assign o_valid         = r_valid;
    assign o_left_out      = r_use_ram ? ram_rdata[SAMPLE_W-1:0] : '0;
    assign o_right_out     = r_use_ram ? ram_rdata[FRAME_W-1:SAMPLE_W] : '0;
    assign o_push_accepted = r_acc;
    assign o_silent        = r_sil;
    assign o_underrun      = r_und;
    assign o_fill_level    = LEVEL_W'(r_count);
    assign o_played_frames = r_played;

    // checks
`include "audio_frame_fifo_prefill_unit_assert.svh"

    `AFP_ASSERT_NEXT(a_result_follows, accept, r_valid)
    `AFP_ASSERT_NOW(a_underrun_silent, r_valid && r_und, r_sil && !r_use_ram)
    `AFP_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_count) <= 32'(DEPTH_FRAMES))
    `AFP_ASSERT_NEXT(a_push_grows, accept && n_acc, r_count == $past(r_count) + CNT_W'(1))

endmodule

FILE: rtl/core/afp_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module afp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/audio_frame_fifo_prefill_unit_test.sv
// self-checking testbench for the audio frame fifo prefill unit
`timescale 1ns / 1ps

module audio_frame_fifo_prefill_unit_test;
    import afp_pkg::*;

    // one result word as the block should deliver it
    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                accepted;
        logic                silent;
        logic                underrun;
        logic [LEVEL_W-1:0]  level;
        logic [PLAYED_W-1:0] played;
    } t_fifo_word;

    // block ports
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       start      = 1'b0;
    logic                       busy;
    logic [1:0]                 i_func     = FUNC_NOP;
    logic signed [SAMPLE_W-1:0] i_left_in  = '0;
    logic signed [SAMPLE_W-1:0] i_right_in = '0;
    logic                       i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx  = CFG_ENABLED;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic                       o_push_accepted;
    logic                       o_silent;
    logic                       o_underrun;
    logic [LEVEL_W-1:0]         o_fill_level;
    logic [PLAYED_W-1:0]        o_played_frames;

    // shadow of the playback state and registers
    logic [FRAME_W-1:0]  ring_frames[$];
    logic                ring_draining = 1'b0;
    logic [PLAYED_W-1:0] played_count  = '0;
    logic                cfg_enabled   = 1'b1;
    logic                cfg_paused    = 1'b0;
    logic                cfg_video     = 1'b0;
    logic [LEVEL_W-1:0]  cfg_start_level = START_LEVEL_RST;

    t_fifo_word expected_words[$];
    int         mismatch_count = 0;
    logic       burst_mode     = 1'b0;

    audio_frame_fifo_prefill_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_push_accepted (o_push_accepted),
        .o_silent        (o_silent),
        .o_underrun      (o_underrun),
        .o_fill_level    (o_fill_level),
        .o_played_frames (o_played_frames)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [SAMPLE_W-1:0] rnd16();
        return SAMPLE_W'($urandom);
    endfunction

    // playback fifo behavior for one accepted word
    function automatic t_fifo_word predict_fifo_word(input t_func f,
                                                     input logic [SAMPLE_W-1:0] l,
                                                     input logic [SAMPLE_W-1:0] r);
        t_fifo_word         w;
        logic [FRAME_W-1:0] frame;
        w = '{default: '0};
        case (f)
            FUNC_PUSH: begin
                if (cfg_enabled && ring_frames.size() < DEPTH_FRAMES) begin
                    ring_frames.push_back({r, l});
                    w.accepted = 1'b1;
                end
            end
            FUNC_PULL: begin
                if (!cfg_enabled || cfg_paused) begin
                    w.silent = 1'b1;
                end else begin
                    // watermark check before draining
                    if (!ring_draining && ring_frames.size() >= cfg_start_level)
                        ring_draining = 1'b1;
                    if (!ring_draining) begin
                        w.silent = 1'b1;
                        if (cfg_video)
                            played_count += 1;
                    end else if (ring_frames.size() > 0) begin
                        frame   = ring_frames.pop_front();
                        w.left  = frame[SAMPLE_W-1:0];
                        w.right = frame[FRAME_W-1:SAMPLE_W];
                        played_count += 1;
                    end else begin
                        // empty while draining: rearm the watermark
                        w.silent      = 1'b1;
                        w.underrun    = 1'b1;
                        ring_draining = 1'b0;
                    end
                end
            end
            FUNC_FLUSH: ring_frames.delete();
            default: ;
        endcase
        w.level  = LEVEL_W'(ring_frames.size());
        w.played = played_count;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // compare every result word with the oldest expectation
    always @(posedge i_clk) begin : word_checker
        t_fifo_word want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with none expected", 32'(o_fill_level), '0);
            end else begin
                want = expected_words.pop_front();
                check_field("left_out", 32'($unsigned(o_left_out)), 32'(want.left));
                check_field("right_out", 32'($unsigned(o_right_out)), 32'(want.right));
                check_field("push_accepted", 32'(o_push_accepted), 32'(want.accepted));
                check_field("silent", 32'(o_silent), 32'(want.silent));
                check_field("underrun", 32'(o_underrun), 32'(want.underrun));
                check_field("fill_level", 32'(o_fill_level), 32'(want.level));
                check_field("played_frames", o_played_frames, want.played);
            end
        end
    end

    // send one command word; start stays high when the next word follows at once
    task automatic issue_word(input t_func f, input logic [SAMPLE_W-1:0] l,
                              input logic [SAMPLE_W-1:0] r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_func     <= f;
        i_left_in  <= l;
        i_right_in <= r;
        do @(posedge i_clk); while (busy);
        expected_words.push_back(predict_fifo_word(f, l, r));
    endtask

    // let every expected word come back, then a short tail
    task automatic wait_words_done();
        start <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // write all four registers; upper bits of the flag writes carry noise
    task automatic set_config(input logic en, input logic pa, input logic vm,
                              input logic [LEVEL_W-1:0] level);
        write_reg(CFG_ENABLED, {16'($urandom), en});
        write_reg(CFG_PAUSED, {16'($urandom), pa});
        write_reg(CFG_VIDEO_MODE, {16'($urandom), vm});
        write_reg(CFG_START_LEVEL, level);
        i_cfg_we        <= 1'b0;
        cfg_enabled     = en;
        cfg_paused      = pa;
        cfg_video       = vm;
        cfg_start_level = level;
    endtask

    // default watermark is far above the stored level
    task automatic test_reset_defaults();
        issue_word(FUNC_PUSH, 16'h0000, 16'hffff);
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_NOP, rnd16(), rnd16());
        issue_word(FUNC_FLUSH, rnd16(), rnd16());
        wait_words_done();
    endtask

    // silence until the watermark, drain, underrun, then prefill again
    task automatic test_prefill_watermark();
        set_config(1'b1, 1'b0, 1'b0, LEVEL_W'(2));
        issue_word(FUNC_PUSH, 16'h8000, 16'h7fff);
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PUSH, 16'h7fff, 16'h8000);
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        wait_words_done();
    endtask

    // zero watermark, video mode counting and flush keeping the drain state
    task automatic test_zero_watermark_video();
        set_config(1'b1, 1'b0, 1'b1, '0);
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PUSH, 16'hffff, 16'h0000);
        issue_word(FUNC_PULL, rnd16(), rnd16());
        wait_words_done();
        set_config(1'b1, 1'b0, 1'b1, LEVEL_W'(3));
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_FLUSH, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        wait_words_done();
    endtask

    // disabled and paused pulls, contents kept, flush while disabled
    task automatic test_disable_and_pause();
        set_config(1'b1, 1'b0, 1'b0, LEVEL_W'(1));
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        wait_words_done();
        set_config(1'b0, 1'b0, 1'b1, LEVEL_W'(1));
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        wait_words_done();
        set_config(1'b1, 1'b1, 1'b1, LEVEL_W'(1));
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        wait_words_done();
        set_config(1'b1, 1'b0, 1'b0, LEVEL_W'(1));
        issue_word(FUNC_PULL, rnd16(), rnd16());
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        wait_words_done();
        set_config(1'b0, 1'b0, 1'b0, LEVEL_W'(1));
        issue_word(FUNC_FLUSH, rnd16(), rnd16());
        wait_words_done();
        set_config(1'b1, 1'b0, 1'b1, '1);
        issue_word(FUNC_PUSH, rnd16(), rnd16());
        issue_word(FUNC_PULL, rnd16(), rnd16());
        wait_words_done();
    endtask

    // mixed traffic over many register settings, level kept low
    task automatic test_random_traffic();
        int                 pick;
        int                 roll;
        int                 push_limit;
        t_func              f;
        logic [LEVEL_W-1:0] level;
        for (int p = 0; p < 12; p++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                level = LEVEL_W'($urandom_range(0, 16));
            else if (pick == 7)
                level = '0;
            else if (pick == 8)
                level = LEVEL_W'(DEPTH_FRAMES);
            else
                level = '1;
            set_config($urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0,
                       1'($urandom_range(0, 1)), level);
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 76; n++) begin
                roll       = $urandom_range(0, 99);
                push_limit = (ring_frames.size() > 24) ? 40 : 55;
                if (roll < 3)
                    f = FUNC_FLUSH;
                else if (roll < 6)
                    f = FUNC_NOP;
                else if (roll < push_limit)
                    f = FUNC_PUSH;
                else
                    f = FUNC_PULL;
                issue_word(f, rnd16(), rnd16());
            end
            wait_words_done();
            burst_mode = 1'b0;
        end
    endtask

    // main sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_prefill_watermark();
        test_zero_watermark_video();
        test_disable_and_pause();
        test_random_traffic();
        wait_words_done();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run time limit
    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
